/* src/mse_pkg.sv */
// shared types and constants for the mpe section to ethernet converter
`default_nettype none

package mse_pkg;

  // result kind carried in tuser
  typedef enum logic [2:0] {
    OUT_FRAME     = 3'd0,
    OUT_SHORT     = 3'd1,
    OUT_SCRAMBLED = 3'd2,
    OUT_BAD_SNAP  = 3'd3,
    OUT_MULTI     = 3'd4
  } outcome_t;

  // work handed from the parser to the frame builder
  typedef enum logic [1:0] {
    CMD_PAYLOAD = 2'd0,
    CMD_HEADER  = 2'd1,
    CMD_DROP    = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
    outcome_t   reason;
  } cmd_t;

  // destination mac (6 bytes) then ethertype (2 bytes), index 0 goes out first
  typedef logic [7:0][7:0] hdr_bytes_t;

  localparam int unsigned HDR_LEN     = 14;
  localparam int unsigned IDX_SAT     = 24;
  localparam int unsigned START_PLAIN = 15;
  localparam int unsigned START_SNAP  = 23;

  localparam logic [7:0] SCRAMBLE_MASK = 8'h3c;

  // keep the lowest nonzero fault code
  function automatic outcome_t fault_merge(input outcome_t cur, input outcome_t code);
    fault_merge = (cur == OUT_FRAME || code < cur) ? code : cur;
  endfunction

endpackage

`default_nettype wire

/* src/mse_front.sv */
// section parser: tracks byte position, captures header fields, issues commands
`default_nettype none

module mse_front
  import mse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire logic       q_full,
  output logic            push,
  output cmd_t            push_cmd,
  input  wire logic       hdr_take,
  output hdr_bytes_t      hdr_slot
);

  logic [4:0] byte_index;
  logic       snap_mode;
  outcome_t   drop_reason;
  logic       frame_started;
  logic       hdr_busy;
  hdr_bytes_t header_capture;
  logic [3:0][7:0] payload_delay;

  logic       accept;
  logic       hdr_need;
  logic [4:0] start_at;
  outcome_t   reason_a;
  outcome_t   reason_b;

  function automatic logic [7:0] snap_byte(input logic [4:0] idx);
    case (idx)
      5'd12, 5'd13: snap_byte = 8'haa;
      5'd14:        snap_byte = 8'h03;
      default:      snap_byte = 8'h00;
    endcase
  endfunction

  always_comb begin
    start_at = snap_mode ? 5'(START_SNAP) : 5'(START_PLAIN);
    hdr_need = !frame_started && (drop_reason == OUT_FRAME) && (byte_index == start_at);

    reason_a = drop_reason;
    if (byte_index == 5'd5 && (in_byte & SCRAMBLE_MASK) != 8'h00) begin
      reason_a = fault_merge(reason_a, OUT_SCRAMBLED);
    end
    if (byte_index == 5'd7 && in_byte != 8'h00) begin
      reason_a = fault_merge(reason_a, OUT_MULTI);
    end
    if (snap_mode && byte_index >= 5'd12 && byte_index <= 5'd17 &&
        in_byte != snap_byte(byte_index)) begin
      reason_a = fault_merge(reason_a, OUT_BAD_SNAP);
    end

    reason_b = reason_a;
    if (byte_index < 5'(START_PLAIN)) begin
      reason_b = fault_merge(reason_b, OUT_SHORT);
    end else if (snap_mode && byte_index < 5'(START_SNAP)) begin
      reason_b = fault_merge(reason_b, OUT_BAD_SNAP);
    end

    in_ready = !q_full && !(hdr_need && hdr_busy);
    accept   = in_valid && in_ready;
    push     = accept && (frame_started || hdr_need || in_last);

    if (frame_started) begin
      push_cmd = '{kind: CMD_PAYLOAD, data: payload_delay[0], last: in_last,
                   reason: OUT_FRAME};
    end else if (hdr_need) begin
      push_cmd = '{kind: CMD_HEADER, data: 8'h00, last: in_last, reason: OUT_FRAME};
    end else begin
      push_cmd = '{kind: CMD_DROP, data: 8'h00, last: 1'b1, reason: reason_b};
    end
  end

  // delay line, header capture and header hand-off slot
  always_ff @(posedge clk) begin
    if (accept) begin
      payload_delay <= {in_byte, payload_delay[3:1]};
      case (byte_index)
        5'd3:  header_capture[5] <= in_byte;
        5'd4:  header_capture[4] <= in_byte;
        5'd8:  header_capture[3] <= in_byte;
        5'd9:  header_capture[2] <= in_byte;
        5'd10: header_capture[1] <= in_byte;
        5'd11: header_capture[0] <= in_byte;
        5'd12: begin
          if (!snap_mode) begin
            header_capture[6] <= (in_byte[7:4] == 4'h6) ? 8'h86 : 8'h08;
            header_capture[7] <= (in_byte[7:4] == 4'h6) ? 8'hdd : 8'h00;
          end
        end
        5'd18: begin
          if (snap_mode) begin
            header_capture[6] <= in_byte;
          end
        end
        5'd19: begin
          if (snap_mode) begin
            header_capture[7] <= in_byte;
          end
        end
        default: ;
      endcase
      if (hdr_need) begin
        hdr_slot <= header_capture;
      end
    end
  end

  // section tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      snap_mode     <= 1'b0;
      drop_reason   <= OUT_FRAME;
      frame_started <= 1'b0;
      hdr_busy      <= 1'b0;
    end else begin
      if (accept && hdr_need) begin
        hdr_busy <= 1'b1;
      end else if (hdr_take) begin
        hdr_busy <= 1'b0;
      end
      if (accept) begin
        if (in_last) begin
          byte_index    <= '0;
          snap_mode     <= 1'b0;
          drop_reason   <= OUT_FRAME;
          frame_started <= 1'b0;
        end else begin
          if (byte_index < 5'(IDX_SAT)) begin
            byte_index <= byte_index + 5'd1;
          end
          if (byte_index == 5'd5) begin
            snap_mode <= in_byte[1];
          end
          drop_reason   <= reason_a;
          frame_started <= frame_started || hdr_need;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* src/mse_queue.sv */
// command queue between the parser and the frame builder
`default_nettype none

module mse_queue
  import mse_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      full,
  output logic      empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/mse_back.sv */
// frame builder: expands commands into output words behind an output register
`default_nettype none

module mse_back
  import mse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_empty,
  input  wire cmd_t       q_head,
  output logic            pop,
  input  wire hdr_bytes_t hdr_slot,
  output logic            hdr_take,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,
  output logic            m_axis_tlast,
  output logic [2:0]      m_axis_tuser
);

  hdr_bytes_t hdr_reg;
  logic       hdr_active;
  logic       hdr_last;
  logic [3:0] hdr_cnt;
  outcome_t   out_code;
  logic       load;

  // header word order: dest mac, six zero bytes of source mac, ethertype
  function automatic logic [7:0] hdr_pick(input hdr_bytes_t h, input logic [3:0] cnt);
    if (cnt < 4'd6) begin
      hdr_pick = h[cnt[2:0]];
    end else if (cnt < 4'd12) begin
      hdr_pick = 8'h00;
    end else begin
      hdr_pick = h[{2'b11, cnt[0]}];
    end
  endfunction

  assign load         = !m_axis_tvalid || m_axis_tready;
  assign pop          = load && !hdr_active && !q_empty;
  assign hdr_take     = pop && (q_head.kind == CMD_HEADER);
  assign m_axis_tuser = out_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      hdr_active    <= 1'b0;
      hdr_cnt       <= '0;
    end else if (load) begin
      if (hdr_active) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= hdr_pick(hdr_reg, hdr_cnt);
        m_axis_tlast  <= (hdr_cnt == 4'(HDR_LEN - 1)) && hdr_last;
        out_code      <= OUT_FRAME;
        hdr_cnt       <= hdr_cnt + 4'd1;
        if (hdr_cnt == 4'(HDR_LEN - 1)) begin
          hdr_active <= 1'b0;
        end
      end else if (!q_empty) begin
        m_axis_tvalid <= 1'b1;
        unique case (q_head.kind)
          CMD_PAYLOAD: begin
            m_axis_tdata <= q_head.data;
            m_axis_tlast <= q_head.last;
            out_code     <= OUT_FRAME;
          end
          CMD_HEADER: begin
            hdr_reg      <= hdr_slot;
            hdr_last     <= q_head.last;
            hdr_active   <= 1'b1;
            hdr_cnt      <= 4'd1;
            m_axis_tdata <= hdr_slot[0];
            m_axis_tlast <= 1'b0;
            out_code     <= OUT_FRAME;
          end
          default: begin
            m_axis_tdata <= 8'h00;
            m_axis_tlast <= 1'b1;
            out_code     <= q_head.reason;
          end
        endcase
      end else begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* src/mpe_section_to_ethernet.sv */
// top level of the mpe section to ethernet frame converter
//
//  channel  dir  tdata          tlast      tuser
//  s_axis   in   section byte   last byte  -
//  m_axis   out  frame byte     last word  outcome (3 bits)
//
// one section byte is taken per cycle; the parser turns each byte into at most one
// command, and the frame builder drains one command word per cycle while the output
// is not stalled, except a header command, which expands into 14 header words
// a header burst is absorbed by the command queue; the input stalls only when the
// queue is full or a second header is due before the builder took the first one
// rst is synchronous and clears the section tracking, queue pointers and output valid
`default_nettype none

module mpe_section_to_ethernet
  import mse_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast,
  output logic [2:0]      m_axis_tuser    // [2:0] outcome
);

  // parser to queue
  logic       push;
  cmd_t       push_cmd;
  // queue to builder
  cmd_t       q_head;
  logic       q_full;
  logic       q_empty;
  logic       pop;
  // header snapshot hand-off
  hdr_bytes_t hdr_slot;
  logic       hdr_take;

  mse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd),
    .hdr_take (hdr_take),
    .hdr_slot (hdr_slot)
  );

  mse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  mse_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .pop           (pop),
    .hdr_slot      (hdr_slot),
    .hdr_take      (hdr_take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire
